[rtl/lfsf_pkg.sv]
`timescale 1ns / 1ps

package lfsf_pkg;

  // Command codes carried in s_tuser
  localparam logic [1:0] CMD_CELL      = 2'd0;
  localparam logic [1:0] CMD_CANDIDATE = 2'd1;
  localparam logic [1:0] CMD_REPORT    = 2'd2;

  localparam int          SIDE_W   = 7;
  localparam logic [6:0]  SIDE_MAX = 7'd127;
  localparam logic [7:0]  FIT_NONE = 8'hFF;  // -1

  typedef logic [SIDE_W-1:0] side_t;

endpackage

[rtl/largest_free_square_fit_unit.sv]
`timescale 1ns / 1ps

// Channel   Dir  Bits  Contents
// s_*       in   8+2   tdata: cell_free[0], candidate_size[7:1]; tuser: command
// m_*       out  16    tdata: best_fit[7:0] (signed), largest_square[14:8]
// cfg_*     in   7     column_count, written when cfg_write is high
//
// One transfer per clock sustained. Two stages: the accept edge updates the
// row position and reads the line buffer (synchronous memory); the
// next cycle forms 1 + min(left, above, above-left), writes it back and
// updates the running maximum. A write and a read of the same column on one
// edge are resolved by forwarding. Only a report waiting on a full output
// register stalls the input. No clearing pass: a fill count marks which line
// buffer columns hold data of the current job. rst is synchronous.
module largest_free_square_fit_unit
  import lfsf_pkg::*;
#(
  parameter int MAX_COLUMNS = 64
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_write,
  input  logic [6:0]  cfg_data,      // column_count
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,       // [0] cell_free, [7:1] candidate_size
  input  logic [1:0]  s_tuser,       // command
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [15:0] m_tdata        // [7:0] best_fit, [14:8] largest_square
);

  localparam int PW = (MAX_COLUMNS > 1) ? $clog2(MAX_COLUMNS) : 1;
  localparam int FW = PW + 1;

  // configuration
  logic [6:0] column_count;

  // row tracking (accept side)
  logic [PW-1:0] column_position;
  logic          first_row;
  logic [FW-1:0] fill;        // columns 0..fill-1 written in this job

  // line buffer
  side_t         row_mem [MAX_COLUMNS];
  side_t         mem_q;
  logic          fwd_hit;
  side_t         fwd_val;

  // process stage register
  logic          p_valid;
  logic [1:0]    p_cmd;
  logic          p_free;
  logic [6:0]    p_size;
  logic [PW-1:0] p_pos;
  logic          p_pos_zero;
  logic          p_first;
  logic          p_up_ok;

  // job state (process side)
  side_t         left_value;
  side_t         diagonal_value;
  side_t         max_side;
  side_t         best;        // zero means no candidate fits
  logic [127:0]  cand_set;

  logic          s_fire;
  logic          p_stall;
  logic          p_cell;
  logic          wrap;
  logic [FW-1:0] pos_inc;

  side_t         up;
  side_t         left;
  side_t         diag;
  side_t         min_v;
  logic  [7:0]   sum;
  side_t         val;

  assign p_stall  = p_valid && (p_cmd == CMD_REPORT) && m_tvalid && !m_tready;
  assign s_tready = !p_stall;
  assign s_fire   = s_tvalid && s_tready;
  assign p_cell   = p_valid && (p_cmd == CMD_CELL);

  assign pos_inc = FW'(column_position) + FW'(1);
  assign wrap    = int'(pos_inc) >= int'(column_count);

  // --- square side of the cell in the process stage
  always_comb begin
    up    = p_up_ok ? (fwd_hit ? fwd_val : mem_q) : '0;
    left  = p_pos_zero ? '0 : left_value;
    diag  = (p_pos_zero || p_first) ? '0 : diagonal_value;
    min_v = (left < up) ? left : up;
    min_v = (min_v < diag) ? min_v : diag;
    sum   = {1'b0, min_v} + 8'd1;
    if (!p_free) begin
      val = '0;
    end else if (sum > {1'b0, SIDE_MAX}) begin
      val = SIDE_MAX;
    end else begin
      val = sum[6:0];
    end
  end

  // --- configuration register; 0 acts as 1, above the buffer depth clamps
  always_ff @(posedge clk) begin
    if (rst) begin
      column_count <= 7'd1;
    end else if (cfg_write) begin
      if (cfg_data == 7'd0) begin
        column_count <= 7'd1;
      end else if (int'(cfg_data) > MAX_COLUMNS) begin
        column_count <= 7'(MAX_COLUMNS);
      end else begin
        column_count <= cfg_data;
      end
    end
  end

  // --- accept side: position, first-row flag, fill count, pipeline register
  always_ff @(posedge clk) begin
    if (rst) begin
      column_position <= '0;
      first_row       <= 1'b1;
      fill            <= '0;
      p_valid         <= 1'b0;
    end else begin
      if (s_fire) begin
        p_valid <= 1'b1;
        case (s_tuser)
          CMD_CELL: begin
            if (wrap) begin
              column_position <= '0;
              first_row       <= 1'b0;
            end else begin
              column_position <= pos_inc[PW-1:0];
            end
            if (pos_inc > fill) begin
              fill <= pos_inc;
            end
          end
          CMD_REPORT: begin
            column_position <= '0;
            first_row       <= 1'b1;
            fill            <= '0;
          end
          default: begin
          end
        endcase
      end else if (!p_stall) begin
        p_valid <= 1'b0;
      end
    end
  end

  // payload of the process stage
  always_ff @(posedge clk) begin
    if (s_fire) begin
      p_cmd      <= s_tuser;
      p_free     <= s_tdata[0];
      p_size     <= s_tdata[7:1];
      p_pos      <= column_position;
      p_pos_zero <= (column_position == '0);
      p_first    <= first_row;
      p_up_ok    <= !first_row && (FW'(column_position) < fill);
    end
  end

  // --- line buffer: write from the process stage, read on accept
  always_ff @(posedge clk) begin
    if (p_cell) begin
      row_mem[p_pos] <= val;
    end
    if (s_fire) begin
      mem_q   <= row_mem[column_position];
      fwd_hit <= p_cell && (p_pos == column_position);
      fwd_val <= val;
    end
  end

  // --- process side: running values, candidates, report
  always_ff @(posedge clk) begin
    if (rst) begin
      max_side <= '0;
      best     <= '0;
      cand_set <= '0;
      m_tvalid <= 1'b0;
    end else begin
      if (m_tready) begin
        m_tvalid <= 1'b0;
      end
      if (p_valid && !p_stall) begin
        case (p_cmd)
          CMD_CELL: begin
            // a cell grows the maximum by at most one
            if (val > max_side) begin
              max_side <= val;
              if (cand_set[val]) begin
                best <= val;
              end
            end
          end
          CMD_CANDIDATE: begin
            if (p_size != 7'd0) begin
              cand_set[p_size] <= 1'b1;
              if (p_size <= max_side && p_size > best) begin
                best <= p_size;
              end
            end
          end
          CMD_REPORT: begin
            m_tvalid <= 1'b1;
            max_side <= '0;
            best     <= '0;
            cand_set <= '0;
          end
          default: begin
          end
        endcase
      end
    end
  end

  // neighbor values; masked by position flags, so no reset needed
  always_ff @(posedge clk) begin
    if (p_cell) begin
      left_value     <= val;
      diagonal_value <= up;
    end
  end

  always_ff @(posedge clk) begin
    if (p_valid && !p_stall && (p_cmd == CMD_REPORT)) begin
      m_tdata[7:0]  <= (best == '0) ? FIT_NONE : {1'b0, best};
      m_tdata[14:8] <= max_side;
      m_tdata[15]   <= 1'b0;
    end
  end

  // --- assertions
  a_best_fits: assert property (@(posedge clk) disable iff (rst)
    best <= max_side)
    else $error("best candidate exceeds largest square");

  a_report_out: assert property (@(posedge clk) disable iff (rst)
    (p_valid && (p_cmd == CMD_REPORT) && !p_stall) |=> m_tvalid)
    else $error("report transfer produced no result");

  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    int'(fill) <= MAX_COLUMNS)
    else $error("fill count beyond line buffer depth");

  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    p_stall |=> (p_valid && (p_cmd == CMD_REPORT)))
    else $error("stalled report lost from process stage");

endmodule

[tb/sv/largest_free_square_fit_unit_tb.sv]
`timescale 1ns / 1ps

module largest_free_square_fit_unit_tb;
  import lfsf_pkg::*;

  // Command 3 has no name in the package; the block drops it without a result.
  localparam logic [1:0] CMD_UNUSED = 2'd3;

  localparam int COLS_MAX     = 64;
  localparam int GRID_ROWS    = 5;    // rows of the all-free full-width grid
  localparam int PHASE_ITEMS  = 170;  // items queued per random phase
  localparam int CYCLE_LIMIT  = 400000;
  localparam int DRAIN_CYCLES = 8;    // two pipe stages plus output register, with margin
  localparam int HOLD_CYCLES  = 300;  // long m_tready hold-off for backpressure

  typedef struct packed {
    logic [1:0] cmd;
    logic       free;
    logic [6:0] size;
  } grid_item_t;

  typedef struct packed {
    logic [7:0] best_fit;
    side_t      largest_square;
  } fit_report_t;

  logic        clk       = 1'b0;
  logic        rst       = 1'b1;
  logic        cfg_write = 1'b0;
  logic [6:0]  cfg_data  = '0;
  logic        s_tvalid  = 1'b0;
  logic        s_tready;
  logic [7:0]  s_tdata   = '0;    // [0] cell_free, [7:1] candidate_size
  logic [1:0]  s_tuser   = '0;    // command
  logic        m_tvalid;
  logic        m_tready  = 1'b0;
  logic [15:0] m_tdata;           // [7:0] best_fit, [14:8] largest_square

  largest_free_square_fit_unit dut (
    .clk      (clk),
    .rst      (rst),
    .cfg_write(cfg_write),
    .cfg_data (cfg_data),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  always #4 clk = ~clk;

  // Stimulus and expectation stores, pacing knobs.
  grid_item_t  item_queue[$];
  fit_report_t fit_reports[$];
  int          gap_pct     = 0;   // percent of free cycles the sender sits idle
  int          stall_pct   = 0;   // percent of cycles the receiver drops m_tready
  int          fail_count  = 0;
  int          cycle_count = 0;
  int          hold_left   = 0;
  logic        hold_go     = 1'b0;

  // ---------------------------------------------------------------------------
  // Predictor: running-minimum square tracking over a one-row line buffer.
  // ---------------------------------------------------------------------------
  int unsigned  col_limit;            // effective column count after clamping
  side_t        side_row[COLS_MAX];   // square sides of the previous row
  side_t        side_left;
  side_t        side_diag;            // above-left, saved before the overwrite
  side_t        side_peak;            // largest side in this job
  int unsigned  col_pos;
  bit           on_top_row;
  logic [127:0] size_seen;            // one bit per candidate size given

  function automatic void clear_grid();
    foreach (side_row[i]) side_row[i] = '0;
    side_left  = '0;
    side_diag  = '0;
    side_peak  = '0;
    col_pos    = 0;
    on_top_row = 1'b1;
    size_seen  = '0;
  endfunction

  // 0 behaves as 1, anything above the line buffer size as the full width
  function automatic void set_columns(logic [6:0] v);
    if (v == 0) col_limit = 1;
    else if (v > COLS_MAX) col_limit = COLS_MAX;
    else col_limit = 32'(v);
  endfunction

  function automatic void grid_step(logic free);
    side_t up, lf, dg, m, val;
    up  = on_top_row ? '0 : side_row[col_pos];
    lf  = (col_pos == 0) ? '0 : side_left;
    dg  = (col_pos == 0 || on_top_row) ? '0 : side_diag;
    m   = (lf < up) ? lf : up;
    if (dg < m) m = dg;
    val = '0;
    if (free) val = (m == SIDE_MAX) ? SIDE_MAX : m + 7'd1;   // saturating side
    side_diag         = up;
    side_left         = val;
    side_row[col_pos] = val;
    if (val > side_peak) side_peak = val;
    // position survives a column count change; wraps once it reaches the count
    if (col_pos + 1 >= col_limit) begin
      col_pos    = 0;
      on_top_row = 1'b0;
    end else begin
      col_pos = col_pos + 1;
    end
  endfunction

  function automatic void predict_transfer(logic [1:0] cmd, logic free, logic [6:0] size);
    fit_report_t r;
    int          s;
    case (cmd)
      CMD_CELL: begin
        grid_step(free);
      end
      CMD_CANDIDATE: begin
        if (size != 0) size_seen[size] = 1'b1;   // size 0 dropped, repeats merge
      end
      CMD_REPORT: begin
        // a size fits exactly when it is no larger than the largest free square
        r.best_fit = FIT_NONE;
        for (s = int'(side_peak); s >= 1 && r.best_fit == FIT_NONE; s--)
          if (size_seen[s]) r.best_fit = 8'(s);
        r.largest_square = side_peak;
        fit_reports.push_back(r);
        clear_grid();
      end
      default: ;
    endcase
  endfunction

  task automatic flag_mismatch(string what);
    $display("MISMATCH at %0t: %s", $time, what);
    fail_count++;
  endtask

  // ---------------------------------------------------------------------------
  // Driver: presents queued items; the predictor sees each completed transfer.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin : item_feed
    grid_item_t nxt;
    if (rst) begin
      s_tvalid <= 1'b0;
    end else begin
      if (s_tvalid && s_tready) predict_transfer(s_tuser, s_tdata[0], s_tdata[7:1]);
      if (!s_tvalid || s_tready) begin
        if (item_queue.size() != 0 && $urandom_range(99) >= gap_pct) begin
          nxt = item_queue.pop_front();
          s_tvalid <= 1'b1;
          s_tuser  <= nxt.cmd;
          s_tdata  <= {nxt.size, nxt.free};
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: checks each result transfer against the oldest expectation.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin : result_check
    fit_report_t want;
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) begin
        if (fit_reports.size() == 0) begin
          flag_mismatch($sformatf("result %h with no report pending", m_tdata));
        end else begin
          want = fit_reports.pop_front();
          if (m_tdata[7:0] !== want.best_fit)
            flag_mismatch($sformatf("best_fit %0d, expected %0d",
                                    $signed(m_tdata[7:0]), $signed(want.best_fit)));
          if (m_tdata[14:8] !== want.largest_square)
            flag_mismatch($sformatf("largest_square %0d, expected %0d",
                                    m_tdata[14:8], want.largest_square));
        end
      end
      m_tready <= (hold_left == 0) && ($urandom_range(99) >= stall_pct);
    end
  end

  // Receiver hold-off counter, kicked once to force the input to back up.
  always @(posedge clk) begin
    if (rst) hold_left <= 0;
    else if (hold_go) hold_left <= HOLD_CYCLES;
    else if (hold_left != 0) hold_left <= hold_left - 1;
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("largest_free_square_fit_unit verification failed");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------
  task automatic push_item(logic [1:0] cmd, logic free, logic [6:0] size);
    item_queue.push_back('{cmd, free, size});
  endtask

  // Mostly sizes near the grid width, some anywhere in 7 bits, some zero.
  function automatic logic [6:0] pick_size();
    int r;
    r = $urandom_range(99);
    if (r < 70) return 7'($urandom_range(1, col_limit + 1));
    if (r < 88) return 7'($urandom_range(1, 127));
    if (r < 94) return 7'd0;
    return (r < 97) ? 7'd127 : 7'd64;
  endfunction

  // One job: cells with candidates sprinkled in, closed by a report. Now and
  // then the grid is cut short mid-row, and stray command-3 items slip in.
  task automatic make_job(int rows, int free_pct, int cand_pct);
    int cells, cut, i;
    cells = rows * col_limit;
    cut   = ($urandom_range(99) < 10) ? $urandom_range(0, cells) : cells;
    for (i = 0; i < cut; i++) begin
      if ($urandom_range(99) < cand_pct)
        push_item(CMD_CANDIDATE, 1'($urandom_range(1)), pick_size());
      if ($urandom_range(99) < 3)
        push_item(CMD_UNUSED, 1'($urandom_range(1)), 7'($urandom_range(127)));
      push_item(CMD_CELL, $urandom_range(99) < free_pct, 7'($urandom_range(127)));
    end
    if ($urandom_range(1)) push_item(CMD_CANDIDATE, 1'($urandom_range(1)), pick_size());
    push_item(CMD_REPORT, 1'($urandom_range(1)), 7'($urandom_range(127)));
  endtask

  task automatic fill_phase(int count, int cand_pct);
    int row_cap, fp;
    row_cap = (col_limit <= 4) ? 16 : (col_limit <= 16) ? 4 : 2;
    while (item_queue.size() < count) begin
      fp = ($urandom_range(2) == 0) ? 50 : ($urandom_range(1) ? 80 : 95);
      make_job($urandom_range(1, row_cap), fp, cand_pct);
    end
    // leave a partial row open so the next column count lands mid-row
    repeat ($urandom_range(3))
      push_item(CMD_CELL, 1'($urandom_range(1)), 7'($urandom_range(127)));
  endtask

  // Idle point: nothing queued or on the bus, no report outstanding, and the
  // pipeline given time to retire cells that produce no result.
  task automatic settle();
    while (item_queue.size() != 0 || s_tvalid || fit_reports.size() != 0)
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_columns(logic [6:0] v);
    settle();
    @(posedge clk);
    cfg_write <= 1'b1;
    cfg_data  <= v;
    @(posedge clk);
    cfg_write <= 1'b0;
    set_columns(v);
  endtask

  task automatic set_pace(int send_gap, int recv_stall);
    @(negedge clk);
    gap_pct   = send_gap;
    stall_pct = recv_stall;
  endtask

  // ---------------------------------------------------------------------------
  // Sequence
  // ---------------------------------------------------------------------------
  initial begin : sequencer
    int i;
    clear_grid();
    set_columns(7'd1);
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed, one column after reset: report on an empty grid, size zero,
    // the unused command, a single free cell, then a blocked one.
    push_item(CMD_REPORT,    1'b0, 7'd0);
    push_item(CMD_CANDIDATE, 1'b1, 7'd0);
    push_item(CMD_UNUSED,    1'b1, 7'h7F);
    push_item(CMD_CELL,      1'b1, 7'h7F);
    push_item(CMD_CANDIDATE, 1'b0, 7'd1);
    push_item(CMD_REPORT,    1'b1, 7'h7F);
    push_item(CMD_CELL,      1'b0, 7'd0);
    push_item(CMD_CANDIDATE, 1'b0, 7'd127);
    push_item(CMD_REPORT,    1'b0, 7'd0);

    // Two columns: repeated and oversized candidates, a full 2x2 square,
    // then a broken square where only size 1 fits.
    write_columns(7'd2);
    @(negedge clk);
    push_item(CMD_CANDIDATE, 1'b0, 7'd2);
    push_item(CMD_CANDIDATE, 1'b1, 7'd2);
    push_item(CMD_CANDIDATE, 1'b0, 7'd64);
    repeat (4) push_item(CMD_CELL, 1'b1, 7'd0);
    push_item(CMD_CANDIDATE, 1'b1, 7'd127);
    push_item(CMD_REPORT,    1'b0, 7'd0);
    push_item(CMD_CELL,      1'b1, 7'd0);
    push_item(CMD_CELL,      1'b0, 7'h7F);
    push_item(CMD_CELL,      1'b1, 7'd0);
    push_item(CMD_CELL,      1'b1, 7'd0);
    push_item(CMD_CANDIDATE, 1'b0, 7'd1);
    push_item(CMD_REPORT,    1'b1, 7'd0);

    // Full width, no idling; an all-free grid a few rows deep, with the
    // fitting candidate arriving mid-grid and larger ones that never fit.
    write_columns(7'd64);
    set_pace(0, 0);
    push_item(CMD_CANDIDATE, 1'b0, 7'd127);
    push_item(CMD_CANDIDATE, 1'b0, 7'd63);
    push_item(CMD_CANDIDATE, 1'b1, 7'(GRID_ROWS - 1));
    for (i = 0; i < COLS_MAX * GRID_ROWS; i++) begin
      if (i == 200) push_item(CMD_CANDIDATE, 1'b1, 7'(GRID_ROWS));
      push_item(CMD_CELL, 1'b1, 7'($urandom_range(127)));
    end
    push_item(CMD_REPORT, 1'b0, 7'd0);
    fill_phase(PHASE_ITEMS, 8);

    // Written zero behaves as one column; sender idles often.
    write_columns(7'd0);
    set_pace(62, 0);
    fill_phase(PHASE_ITEMS, 15);

    // All ones clamps to full width; receiver stalls often.
    write_columns(7'd127);
    set_pace(0, 62);
    fill_phase(PHASE_ITEMS, 8);

    // Narrow random width, light idling on both sides.
    write_columns(7'($urandom_range(2, 12)));
    set_pace(16, 16);
    fill_phase(PHASE_ITEMS, 12);

    // Backpressure: full-rate input while the output is held off for a long
    // stretch; short jobs so reports pile up behind the output register.
    write_columns(7'd3);
    set_pace(0, 0);
    fill_phase(PHASE_ITEMS, 25);
    @(posedge clk);
    hold_go <= 1'b1;
    @(posedge clk);
    hold_go <= 1'b0;

    // Any written value, light idling.
    write_columns(7'($urandom_range(0, 127)));
    set_pace(16, 16);
    fill_phase(PHASE_ITEMS, 12);

    settle();
    if (fail_count == 0)
      $display("largest_free_square_fit_unit verification clean");
    else
      $display("largest_free_square_fit_unit verification failed");
    $finish;
  end

endmodule

[files.f]
rtl/lfsf_pkg.sv
rtl/largest_free_square_fit_unit.sv
tb/sv/largest_free_square_fit_unit_tb.sv
